### hw/rtl/sfx_pkg.sv
// Shared types and constants of the sound effect voice engine.
package sfx_pkg;

    // Command codes
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_TRIGGER = 2'd1;
    localparam logic [1:0] CMD_STOP    = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    // Result action codes
    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_STOP   = 2'd2;

    // Pitch modes
    localparam logic [1:0] MODE_HALF   = 2'd1;
    localparam logic [1:0] MODE_THIRDS = 2'd2;

    // Percent trim
    localparam logic [7:0] PCT_FULL = 8'd100;
    localparam logic [6:0] PCT_T0   = 7'd90;
    localparam logic [6:0] PCT_T1   = 7'd60;
    localparam logic [6:0] PCT_T2   = 7'd35;
    localparam logic [6:0] PCT_T3   = 7'd15;

    // Divide by 100 as (x * RECIP_100) >> RECIP_SH, exact for x below 2^20
    localparam logic [19:0] RECIP_100 = 20'd671089;
    localparam int          RECIP_SH  = 26;

    // Divider width: magnitude of a glide product
    localparam int DIV_W = 24;

    typedef struct packed {
        logic [1:0]  command;
        logic        is_noise;
        logic [2:0]  waveform;
        logic [1:0]  pitch_mode;
        logic [7:0]  length_frames;
        logic [15:0] hz_start;
        logic [15:0] hz_next;
        logic [15:0] hz_final;
        logic [11:0] level_start;
        logic [11:0] level_end;
    } sfx_in_t;

    typedef struct packed {
        logic [2:0]  channel;
        logic [1:0]  action;
        logic [2:0]  wave_out;
        logic [11:0] level_out;
        logic [15:0] pitch_hz;
        logic        last;
    } sfx_out_t;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [DIV_W-1:0] mag;
        logic [7:0]       den;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [DIV_W:0] quo;   // two's complement
    } div_rsp_t;

endpackage

### hw/rtl/sfx_ifs.sv
// Handshake interfaces of the sound effect voice engine.
interface sfx_req_if;
    import sfx_pkg::*;
    logic    valid;
    logic    ready;
    sfx_in_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sfx_rsp_if;
    import sfx_pkg::*;
    logic     valid;
    logic     ready;
    sfx_out_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sfx_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/sfx_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
module sfx_div
    import sfx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    localparam int CW = $clog2(DIV_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [7:0]       rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [7:0]       den_reg;
    logic             neg_reg;

    logic [8:0] rem_sh;
    logic [8:0] rem_sub;
    logic       ge;

    // Restoring step
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[DIV_W-1]};
        ge      = (rem_sh >= {1'b0, den_reg});
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.mag;
            den_reg <= req.den;
            neg_reg <= req.neg;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[7:0] : rem_sh[7:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = neg_reg ? -{1'b0, quo_reg} : {1'b0, quo_reg};

endmodule

### hw/rtl/sound_effect_voice_engine.sv
// Sound effect voice engine: voice allocation, per-tick stepping and result sequencing.
// Trigger: noise goes straight to the load step; tone first scans the tone voices, one a cycle.
// Tick: each voice is checked in turn; an active voice runs the pitch and level glides, each
// waiting on the divider, and a tone voice also the percent scaling; a length-one glide skips
// the divider. Stop-all stops each busy voice in turn. A stalled result word holds the sequencer.
// One command at a time; req.ready is high only between commands.
// Reset clears busy flags, steps, stamps and the counter; percent resets to 100.
module sound_effect_voice_engine
    import sfx_pkg::*;
#(
    parameter int TONE_VOICES = 4,
    parameter int LEVEL_MAX   = 4095,
    parameter int NOISE_MUTE  = 16
)
(
    input logic         clk,
    input logic         rst_n,
    sfx_req_if.sink     req,
    sfx_rsp_if.source   rsp,
    sfx_cfg_if.sink     cfg
);
    localparam int NV = TONE_VOICES + 1;
    localparam int VW = $clog2(NV);
    localparam int SW = (TONE_VOICES > 1) ? $clog2(TONE_VOICES) : 1;
    localparam logic [VW-1:0] NOISE_V = VW'(TONE_VOICES);
    localparam logic [VW-1:0] LAST_T  = VW'(TONE_VOICES - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_LOAD, S_CHECK,
        S_HZ_MUL, S_HZ_GO, S_HZ_WAIT,
        S_LV_MUL, S_LV_GO, S_LV_WAIT,
        S_VOL, S_VOL_GO, S_VOL_WAIT, S_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  frames;
        logic [2:0]  wave;
        logic [15:0] hz0;
        logic [15:0] hz1;
        logic [15:0] hz2;
        logic [11:0] lv0;
        logic [11:0] lv1;
    } vdef_t;

    state_t                state_reg;
    sfx_in_t               cmd_reg;
    logic [VW-1:0]         v_reg;
    logic [VW-1:0]         pick_reg;
    logic                  found_reg;
    logic                  have_reg;
    logic [31:0]           best_reg;
    logic                  stopall_reg;
    logic [NV-1:0]         busy_reg;
    logic [7:0]            step_reg [NV];
    logic [31:0]           stamp_reg [TONE_VOICES];
    logic [31:0]           stamp_cnt_reg;
    logic [6:0]            pct_reg;
    vdef_t                 vdef_mem [NV];
    logic signed [40:0]    prod_reg;
    logic [15:0]           hz_reg;
    logic [12:0]           lv_reg;
    sfx_out_t              res_reg;
    sfx_out_t              out_reg;
    logic                  out_valid_reg;

    vdef_t                 cur;
    logic [7:0]            cur_i;
    logic [7:0]            pct_eff;
    logic [4:0]            trim;
    logic signed [19:0]    mul_a;
    logic [19:0]           mul_b;
    logic signed [40:0]    mul_p;
    div_req_t              dreq;
    div_rsp_t              drsp;
    logic                  short_glide;
    logic                  half_lo;
    logic                  third_lo;
    logic                  third_mid;
    logic [9:0]            i3;
    logic [15:0]           hz_glide;
    logic [15:0]           hz_sel;
    logic [13:0]           noise_sum;
    logic [11:0]           noise_lv;
    logic [12:0]           vol_q;
    logic [11:0]           tone_lv;
    logic                  cur_noise;
    logic [NV-1:0]         busy_above;
    logic [SW-1:0]         sidx;
    sfx_out_t              emit_word;
    logic                  emit_go;

    sfx_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // Current voice view and small compares
    always_comb
    begin
        cur         = vdef_mem[v_reg];
        cur_i       = step_reg[v_reg];
        cur_noise   = (v_reg == NOISE_V);
        sidx        = SW'(v_reg);
        pct_eff     = ({1'b0, pct_reg} > PCT_FULL) ? PCT_FULL : {1'b0, pct_reg};
        short_glide = (cur.frames < 8'd2);
        half_lo     = ({cur_i, 1'b0} < {1'b0, cur.frames});
        i3          = {2'b00, cur_i} + {1'b0, cur_i, 1'b0};
        third_lo    = (i3 < {2'b00, cur.frames});
        third_mid   = (i3 < {1'b0, cur.frames, 1'b0});
        busy_above  = (busy_reg >> v_reg) >> 1;
    end

    // Noise trim from the percent
    always_comb
    begin
        if (pct_eff[6:0] >= PCT_T0)      trim = 5'd0;
        else if (pct_eff[6:0] >= PCT_T1) trim = 5'd1;
        else if (pct_eff[6:0] >= PCT_T2) trim = 5'd2;
        else if (pct_eff[6:0] >= PCT_T3) trim = 5'd3;
        else if (pct_eff != 8'd0)        trim = 5'd4;
        else                             trim = 5'(NOISE_MUTE);
    end

    // Shared multiplier: glide products, percent scaling, divide by 100
    always_comb
    begin
        case (state_reg)
            S_HZ_MUL:
            begin
                mul_a = $signed({4'd0, cur.hz1}) - $signed({4'd0, cur.hz0});
                mul_b = {12'd0, cur_i};
            end
            S_LV_MUL:
            begin
                mul_a = $signed({8'd0, cur.lv1}) - $signed({8'd0, cur.lv0});
                mul_b = {12'd0, cur_i};
            end
            S_VOL_GO:
            begin
                mul_a = $signed(prod_reg[19:0]);
                mul_b = RECIP_100;
            end
            default:
            begin
                mul_a = $signed({7'd0, lv_reg});
                mul_b = {12'd0, pct_eff};
            end
        endcase
        mul_p = mul_a * $signed({1'b0, mul_b});
    end

    // Divider request
    always_comb
    begin
        dreq.start = (state_reg == S_HZ_GO || state_reg == S_LV_GO) && !short_glide;
        dreq.neg   = prod_reg[40];
        dreq.mag   = prod_reg[40] ? DIV_W'(-prod_reg) : DIV_W'(prod_reg);
        dreq.den   = cur.frames;
    end

    // Pitch by mode, level clamps
    always_comb
    begin
        hz_glide = short_glide ? cur.hz1 : 16'($signed({9'd0, cur.hz0}) + $signed(drsp.quo));
        case (cur.mode)
            MODE_HALF:   hz_sel = half_lo ? cur.hz0 : cur.hz1;
            MODE_THIRDS: hz_sel = third_lo ? cur.hz0 : (third_mid ? cur.hz1 : cur.hz2);
            default:     hz_sel = hz_glide;
        endcase
        noise_sum = {1'b0, lv_reg} + {9'd0, trim};
        noise_lv  = (noise_sum > 14'(NOISE_MUTE)) ? 12'(NOISE_MUTE) : 12'(noise_sum);
        vol_q     = prod_reg[RECIP_SH+12:RECIP_SH];
        tone_lv   = ({19'd0, vol_q} > 32'(LEVEL_MAX)) ? 12'(LEVEL_MAX) : vol_q[11:0];
    end

    // Outgoing word and its handoff condition
    always_comb
    begin
        emit_word      = res_reg;
        emit_word.last = (busy_above == '0);
        emit_go        = (state_reg == S_EMIT) && (!out_valid_reg || rsp.ready);
    end

    // Effect definitions, written on a trigger
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
        begin
            vdef_mem[pick_reg] <= '{mode: cmd_reg.pitch_mode, frames: cmd_reg.length_frames,
                                    wave: cmd_reg.waveform, hz0: cmd_reg.hz_start,
                                    hz1: cmd_reg.hz_next, hz2: cmd_reg.hz_final,
                                    lv0: cmd_reg.level_start, lv1: cmd_reg.level_end};
        end
    end

    // Datapath registers without reset
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req.valid)
            cmd_reg <= req.data;
        if (state_reg == S_HZ_MUL || state_reg == S_LV_MUL || state_reg == S_VOL
            || state_reg == S_VOL_GO)
            prod_reg <= mul_p;
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            v_reg         <= '0;
            pick_reg      <= '0;
            found_reg     <= 1'b0;
            have_reg      <= 1'b0;
            best_reg      <= '0;
            stopall_reg   <= 1'b0;
            busy_reg      <= '0;
            step_reg      <= '{default: '0};
            stamp_reg     <= '{default: '0};
            stamp_cnt_reg <= '0;
            pct_reg       <= 7'(PCT_FULL);
            hz_reg        <= '0;
            lv_reg        <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                pct_reg <= cfg.data;
            if (out_valid_reg && rsp.ready && !emit_go)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        v_reg     <= '0;
                        found_reg <= 1'b0;
                        have_reg  <= 1'b0;
                        case (req.data.command)
                            CMD_TICK:
                            begin
                                stopall_reg <= 1'b0;
                                state_reg   <= S_CHECK;
                            end
                            CMD_STOP:
                            begin
                                stopall_reg <= 1'b1;
                                state_reg   <= S_CHECK;
                            end
                            CMD_TRIGGER:
                            begin
                                if (req.data.is_noise)
                                begin
                                    pick_reg  <= NOISE_V;
                                    state_reg <= S_LOAD;
                                end
                                else
                                    state_reg <= S_SCAN;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end

                // First free tone voice, else oldest stamp
                S_SCAN:
                begin
                    if (!found_reg)
                    begin
                        if (!busy_reg[v_reg])
                        begin
                            pick_reg  <= v_reg;
                            found_reg <= 1'b1;
                        end
                        else if (!have_reg || stamp_reg[sidx] < best_reg)
                        begin
                            pick_reg <= v_reg;
                            best_reg <= stamp_reg[sidx];
                            have_reg <= 1'b1;
                        end
                    end
                    if (v_reg == LAST_T)
                        state_reg <= S_LOAD;
                    else
                        v_reg <= v_reg + 1'b1;
                end

                S_LOAD:
                begin
                    stamp_cnt_reg      <= stamp_cnt_reg + 32'd1;
                    if (pick_reg != NOISE_V)
                        stamp_reg[SW'(pick_reg)] <= stamp_cnt_reg + 32'd1;
                    step_reg[pick_reg] <= '0;
                    busy_reg[pick_reg] <= 1'b1;
                    state_reg          <= S_IDLE;
                end

                S_CHECK:
                begin
                    if (!busy_reg[v_reg])
                    begin
                        if (v_reg == NOISE_V)
                            state_reg <= S_IDLE;
                        else
                            v_reg <= v_reg + 1'b1;
                    end
                    else if (stopall_reg || cur_i >= cur.frames)
                    begin
                        busy_reg[v_reg] <= 1'b0;
                        res_reg   <= '{channel: 3'(v_reg), action: ACT_STOP, wave_out: 3'd0,
                                       level_out: 12'd0, pitch_hz: 16'd0, last: 1'b0};
                        state_reg <= S_EMIT;
                    end
                    else
                        state_reg <= S_HZ_MUL;
                end

                S_HZ_MUL: state_reg <= S_HZ_GO;

                S_HZ_GO:
                begin
                    if (short_glide)
                    begin
                        hz_reg    <= hz_sel;
                        state_reg <= S_LV_MUL;
                    end
                    else
                        state_reg <= S_HZ_WAIT;
                end

                S_HZ_WAIT:
                begin
                    if (drsp.done)
                    begin
                        hz_reg    <= hz_sel;
                        state_reg <= S_LV_MUL;
                    end
                end

                S_LV_MUL: state_reg <= S_LV_GO;

                S_LV_GO:
                begin
                    if (short_glide)
                    begin
                        lv_reg    <= {1'b0, cur.lv1};
                        state_reg <= S_VOL;
                    end
                    else
                        state_reg <= S_LV_WAIT;
                end

                S_LV_WAIT:
                begin
                    if (drsp.done)
                    begin
                        lv_reg    <= 13'($signed({13'd0, cur.lv0}) + $signed(drsp.quo));
                        state_reg <= S_VOL;
                    end
                end

                S_VOL:
                begin
                    if (cur_noise)
                    begin
                        res_reg   <= '{channel: 3'(v_reg),
                                       action: (cur_i == 8'd0) ? ACT_START : ACT_UPDATE,
                                       wave_out: 3'd0, level_out: noise_lv,
                                       pitch_hz: hz_reg, last: 1'b0};
                        state_reg <= S_EMIT;
                    end
                    else
                        state_reg <= S_VOL_GO;
                end

                S_VOL_GO: state_reg <= S_VOL_WAIT;

                // Scaled tone level is in the product register
                S_VOL_WAIT:
                begin
                    res_reg   <= '{channel: 3'(v_reg),
                                   action: (cur_i == 8'd0) ? ACT_START : ACT_UPDATE,
                                   wave_out: (cur_i == 8'd0) ? cur.wave : 3'd0,
                                   level_out: tone_lv, pitch_hz: hz_reg, last: 1'b0};
                    state_reg <= S_EMIT;
                end

                // Hand the word to the output register
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_reg       <= emit_word;
                        out_valid_reg <= 1'b1;
                        if (res_reg.action != ACT_STOP)
                            step_reg[v_reg] <= cur_i + 8'd1;
                        if (v_reg == NOISE_V)
                            state_reg <= S_IDLE;
                        else
                        begin
                            v_reg     <= v_reg + 1'b1;
                            state_reg <= S_CHECK;
                        end
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

endmodule

### hw/rtl/sfx_chk.sv
// Port-level checker for the sound effect voice engine, bound to the top level.
module sfx_chk
    import sfx_pkg::*;
#(
    parameter int TONE_VOICES = 4
)
(
    input logic     clk,
    input logic     rst_n,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input sfx_out_t rsp_data,
    input logic     req_ready
);
    // A stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result word changed while stalled");

    // Channel is a real voice
    a_chan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.channel <= 3'(TONE_VOICES))
        else $error("channel out of range");

    // A stop carries no pitch and no level
    a_stop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.action == ACT_STOP
        |-> rsp_data.pitch_hz == 16'd0 && rsp_data.level_out == 12'd0)
        else $error("stop with pitch or level");

    // Waveform only on a tone start
    a_wave: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.wave_out != 3'd0
        |-> rsp_data.action == ACT_START && rsp_data.channel != 3'(TONE_VOICES))
        else $error("waveform outside a tone start");

    // A new word never appears while a command is being taken
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("result word without a command in progress");

endmodule

bind sound_effect_voice_engine sfx_chk #(.TONE_VOICES(TONE_VOICES)) u_sfx_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data),
    .req_ready (req.ready)
);
